>>> hdl/sgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sgc_pkg;

  typedef enum logic [2:0] {
    KIND_SELECT = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_READ   = 3'd2,
    KIND_TICK   = 3'd3,
    KIND_PORT   = 3'd4
  } sgc_kind_t;

  typedef enum logic {
    RES_READ = 1'b0,
    RES_TICK = 1'b1
  } sgc_res_t;

  localparam logic [3:0] REG_TONE_A_HI = 4'd1;
  localparam logic [3:0] REG_TONE_B_HI = 4'd3;
  localparam logic [3:0] REG_TONE_C_HI = 4'd5;
  localparam logic [3:0] REG_NOISE     = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_VOL_A     = 4'd8;
  localparam logic [3:0] REG_VOL_B     = 4'd9;
  localparam logic [3:0] REG_VOL_C     = 4'd10;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;
  localparam logic [3:0] REG_PORT      = 4'd14;

  localparam logic [7:0] READ_NONE = 8'hFF;

  typedef struct packed {
    logic [2:0][11:0] tone_per;
    logic [4:0]       noise_per;
    logic [5:0]       mixer;
    logic [2:0][4:0]  vol;
    logic [15:0]      env_per;
    logic [3:0]       env_shape;
  } sgc_regs_t;

  typedef struct packed {
    logic restart;
    logic rising;
  } sgc_env_restart_t;

  function automatic logic [7:0] sgc_mask(input logic [3:0] r, input logic [7:0] v);
    logic [7:0] m;
    case (r) inside
      REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI, REG_ENV_SHAPE: m = v & 8'h0F;
      REG_NOISE, REG_VOL_A, REG_VOL_B, REG_VOL_C:                m = v & 8'h1F;
      REG_MIXER:                                                 m = v & 8'h3F;
      default:                                                   m = v;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sgc_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sgc_regs import sgc_pkg::*; #(
  parameter int NUM_REGS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             sel_en,
  input  wire logic             wr_en,
  input  wire logic             port_en,
  input  wire logic [7:0]       data,
  output logic      [7:0]       rd_data,
  output sgc_regs_t             regs,
  output sgc_env_restart_t      env_restart
);

  localparam int IDX_W = $clog2(NUM_REGS);

  logic [NUM_REGS-1:0][7:0] regs_r, regs_nxt;
  logic [7:0]               sel_r;
  logic [7:0]               port_r;
  logic                     sel_ok;
  logic [IDX_W-1:0]         idx;
  logic [7:0]               wr_val;

  assign sel_ok = sel_r < 8'(NUM_REGS);
  assign idx    = sel_r[IDX_W-1:0];
  assign wr_val = sgc_mask(4'(sel_r), data);

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en && sel_ok) begin
      regs_nxt[idx] = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
      sel_r  <= '0;
      port_r <= '0;
    end else begin
      regs_r <= regs_nxt;
      if (sel_en) begin
        sel_r <= data;
      end
      if (port_en) begin
        port_r <= data;
      end
    end
  end

  always_comb begin
    if (sel_r == 8'(REG_PORT)) begin
      rd_data = port_r;
    end else if (!sel_ok) begin
      rd_data = READ_NONE;
    end else begin
      rd_data = regs_r[idx];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      regs.tone_per[c] = {regs_r[2*c+1][3:0], regs_r[2*c]};
      regs.vol[c]      = regs_r[8+c][4:0];
    end
    regs.noise_per = regs_r[6][4:0];
    regs.mixer     = regs_r[7][5:0];
    regs.env_per   = {regs_r[12], regs_r[11]};
    regs.env_shape = regs_r[13][3:0];
  end

  assign env_restart.restart = wr_en && (sel_r == 8'(REG_ENV_SHAPE));
  assign env_restart.rising  = wr_val[2];

endmodule

`default_nettype wire

>>> hdl/sgc_gen.sv
`timescale 1ns / 1ps
`default_nettype none

module sgc_gen import sgc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             tick_en,
  input  wire sgc_regs_t        regs,
  input  wire sgc_env_restart_t env_restart,
  output logic [2:0][3:0]       amp
);

  logic [2:0][14:0] tone_cnt_r, tone_cnt_nxt;
  logic [2:0]       tone_lvl_r, tone_lvl_nxt;
  logic [8:0]       noise_cnt_r, noise_cnt_nxt;
  logic [16:0]      noise_sh_r, noise_sh_nxt;
  logic [18:0]      env_cnt_r, env_cnt_nxt;
  logic [4:0]       env_step_r, env_step_nxt;
  logic             env_frozen_r, env_frozen_nxt;
  logic             env_rising_r, env_rising_nxt;

  logic [11:0] tp;
  logic [14:0] tinc;
  logic [4:0]  np;
  logic [8:0]  ninc;
  logic [15:0] ep;
  logic [18:0] einc;
  logic [3:0]  level;
  logic        t_off, n_off, th, nh;
  logic [3:0]  vol;

  // tone dividers
  always_comb begin
    tp   = '0;
    tinc = '0;
    for (int c = 0; c < 3; c++) begin
      tp   = (regs.tone_per[c] == '0) ? 12'd1 : regs.tone_per[c];
      tinc = tone_cnt_r[c] + 15'd1;
      if (tinc >= {tp, 3'b000}) begin
        tone_cnt_nxt[c] = '0;
        tone_lvl_nxt[c] = ~tone_lvl_r[c];
      end else begin
        tone_cnt_nxt[c] = tinc;
        tone_lvl_nxt[c] = tone_lvl_r[c];
      end
    end
  end

  // noise lfsr
  always_comb begin
    np   = (regs.noise_per == '0) ? 5'd1 : regs.noise_per;
    ninc = noise_cnt_r + 9'd1;
    if (ninc >= {np, 4'b0000}) begin
      noise_cnt_nxt = '0;
      noise_sh_nxt  = {noise_sh_r[0] ^ noise_sh_r[3], noise_sh_r[16:1]};
    end else begin
      noise_cnt_nxt = ninc;
      noise_sh_nxt  = noise_sh_r;
    end
  end

  // envelope
  always_comb begin
    env_cnt_nxt    = env_cnt_r;
    env_step_nxt   = env_step_r;
    env_frozen_nxt = env_frozen_r;
    env_rising_nxt = env_rising_r;
    ep             = (regs.env_per == '0) ? 16'd1 : regs.env_per;
    einc           = env_cnt_r + 19'd1;
    if (!env_frozen_r) begin
      env_cnt_nxt = einc;
      if (einc >= {ep, 3'b000}) begin
        env_cnt_nxt = '0;
        if (env_step_r == 5'd31) begin
          if (!regs.env_shape[3]) begin
            env_step_nxt   = env_rising_r ? 5'd0 : 5'd31;
            env_frozen_nxt = 1'b1;
          end else begin
            if (regs.env_shape[1]) begin
              env_rising_nxt = ~env_rising_r;
            end
            env_step_nxt   = regs.env_shape[0] ? 5'd31 : 5'd0;
            env_frozen_nxt = regs.env_shape[0];
          end
        end else begin
          env_step_nxt = env_step_r + 5'd1;
        end
      end
    end
    level = env_rising_nxt ? env_step_nxt[4:1] : ~env_step_nxt[4:1];
  end

  // mixer
  always_comb begin
    t_off = 1'b0;
    n_off = 1'b0;
    th    = 1'b0;
    nh    = 1'b0;
    vol   = '0;
    for (int c = 0; c < 3; c++) begin
      t_off  = regs.mixer[c];
      n_off  = regs.mixer[c+3];
      th     = t_off | tone_lvl_nxt[c];
      nh     = n_off | noise_sh_nxt[0];
      vol    = regs.vol[c][4] ? level : regs.vol[c][3:0];
      amp[c] = (!(t_off && n_off) && th && nh) ? vol : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_cnt_r   <= '0;
      tone_lvl_r   <= '0;
      noise_cnt_r  <= '0;
      noise_sh_r   <= 17'd1;
      env_cnt_r    <= '0;
      env_step_r   <= '0;
      env_frozen_r <= 1'b0;
      env_rising_r <= 1'b0;
    end else if (env_restart.restart) begin
      env_cnt_r    <= '0;
      env_step_r   <= '0;
      env_frozen_r <= 1'b0;
      env_rising_r <= env_restart.rising;
    end else if (tick_en) begin
      tone_cnt_r   <= tone_cnt_nxt;
      tone_lvl_r   <= tone_lvl_nxt;
      noise_cnt_r  <= noise_cnt_nxt;
      noise_sh_r   <= noise_sh_nxt;
      env_cnt_r    <= env_cnt_nxt;
      env_step_r   <= env_step_nxt;
      env_frozen_r <= env_frozen_nxt;
      env_rising_r <= env_rising_nxt;
    end
  end

  a_frozen_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    env_frozen_r |-> (env_step_r == 5'd0 || env_step_r == 5'd31))
    else $error("frozen envelope off an end step");

  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    noise_sh_r != '0)
    else $error("noise lfsr stuck at zero");

endmodule

`default_nettype wire

>>> hdl/sound_generator_core_top.sv
// channel  dir  handshake             payload
// in_      in   in_valid / in_stall   in_kind, in_data
// out_     out  out_valid / out_stall out_result_kind, out_read_data, out_amp_a/b/c
//
// one item per cycle while in_stall is low; a result passes through the input register
// and then the result register before out_valid rises
// rst_n is synchronous; clears the register file, select, port byte and generator state
// the result register holds while out_stall is high; items with no result keep flowing,
// items with a result wait until the result register frees

`timescale 1ns / 1ps
`default_nettype none

module sound_generator_core_top import sgc_pkg::*; #(
  parameter int NUM_REGS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_kind,
  input  wire logic [7:0] in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_result_kind,
  output logic [7:0]      out_read_data,
  output logic [3:0]      out_amp_a,
  output logic [3:0]      out_amp_b,
  output logic [3:0]      out_amp_c
);

  logic             s1_valid_r;
  sgc_kind_t        s1_kind_r;
  logic [7:0]       s1_data_r;
  logic             out_valid_r;
  sgc_res_t         out_kind_r;
  logic [7:0]       out_data_r;
  logic [2:0][3:0]  out_amp_r;

  logic             need_res;
  logic             adv;
  logic             in_xfer;
  logic [7:0]       rd_data;
  logic [2:0][3:0]  amp;
  sgc_regs_t        regs;
  sgc_env_restart_t env_restart;

  assign need_res = (s1_kind_r == KIND_READ) || (s1_kind_r == KIND_TICK);
  assign adv      = s1_valid_r && (!need_res || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  sgc_regs #(.NUM_REGS(NUM_REGS)) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .sel_en      (adv && s1_kind_r == KIND_SELECT),
    .wr_en       (adv && s1_kind_r == KIND_WRITE),
    .port_en     (adv && s1_kind_r == KIND_PORT),
    .data        (s1_data_r),
    .rd_data     (rd_data),
    .regs        (regs),
    .env_restart (env_restart)
  );

  sgc_gen u_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (adv && s1_kind_r == KIND_TICK),
    .regs        (regs),
    .env_restart (env_restart),
    .amp         (amp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= sgc_kind_t'(in_kind);
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && need_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && need_res) begin
      case (s1_kind_r)
        KIND_TICK: begin
          out_kind_r <= RES_TICK;
          out_data_r <= '0;
          out_amp_r  <= amp;
        end
        default: begin
          out_kind_r <= RES_READ;
          out_data_r <= rd_data;
          out_amp_r  <= '0;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_read_data   = out_data_r;
  assign out_amp_a       = out_amp_r[0];
  assign out_amp_b       = out_amp_r[1];
  assign out_amp_c       = out_amp_r[2];

  a_tick_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RES_TICK) |-> out_read_data == '0)
    else $error("tick result carries read data");

  a_read_no_amp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RES_READ) |->
      (out_amp_a == '0 && out_amp_b == '0 && out_amp_c == '0))
    else $error("read reply carries amplitudes");

  a_silent_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !need_res) |-> !in_stall)
    else $error("item without result blocked");

endmodule

`default_nettype wire

>>> tb/sgc_checker.sv
`timescale 1ns / 1ps

module sgc_checker import sgc_pkg::*; #(
  parameter int NUM_REGS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_kind,
  input  logic [7:0] in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_result_kind,
  input  logic [7:0] out_read_data,
  input  logic [3:0] out_amp_a,
  input  logic [3:0] out_amp_b,
  input  logic [3:0] out_amp_c,
  output int         err_count,
  output int         outstanding
);

  typedef struct packed {
    sgc_res_t   kind;
    logic [7:0] value;
    logic [3:0] amp_a;
    logic [3:0] amp_b;
    logic [3:0] amp_c;
  } psg_out_t;

  localparam int ENV_PER_LO = 11;
  localparam int ENV_PER_HI = 12;

  logic [7:0]  psg_reg [16];
  logic [7:0]  cur_sel;
  logic [14:0] tone_div [3];
  logic [2:0]  tone_out;
  logic [8:0]  noise_div;
  logic [16:0] lfsr;
  logic [18:0] env_div;
  logic [4:0]  env_pos;
  logic        env_freeze;
  logic        env_up;
  logic [7:0]  port_val;

  psg_out_t predicted_outputs [$];

  always @(posedge clk) begin : track
    psg_out_t        exp_res;
    psg_out_t        got;
    logic [7:0]      wv;
    int              per;
    int              nxt;
    int              step;
    int              lvl;
    int              vol;
    logic [3:0]      shape;
    logic            fb;
    logic            t_off;
    logic            n_off;
    logic            th;
    logic            nh;
    logic [2:0][3:0] amps;

    if (!rst_n) begin
      for (int i = 0; i < 16; i++) psg_reg[i] = '0;
      for (int i = 0; i < 3; i++) tone_div[i] = '0;
      cur_sel    = '0;
      tone_out   = '0;
      noise_div  = '0;
      lfsr       = 17'd1;
      env_div    = '0;
      env_pos    = '0;
      env_freeze = 1'b0;
      env_up     = 1'b0;
      port_val   = '0;
      err_count  = 0;
      predicted_outputs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.kind  = sgc_res_t'(out_result_kind);
        got.value = out_read_data;
        got.amp_a = out_amp_a;
        got.amp_b = out_amp_b;
        got.amp_c = out_amp_c;
        if (predicted_outputs.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result: kind %0d data %h amps %h %h %h",
                     got.kind, got.value, got.amp_a, got.amp_b, got.amp_c);
          err_count++;
        end else begin
          exp_res = predicted_outputs.pop_front();
          if (got.kind !== exp_res.kind || got.value !== exp_res.value ||
              got.amp_a !== exp_res.amp_a || got.amp_b !== exp_res.amp_b ||
              got.amp_c !== exp_res.amp_c) begin
            if (err_count < 10)
              $display({"mismatch: expected kind %0d data %h amps %h %h %h, ",
                        "got kind %0d data %h amps %h %h %h"},
                       exp_res.kind, exp_res.value, exp_res.amp_a, exp_res.amp_b,
                       exp_res.amp_c, got.kind, got.value, got.amp_a, got.amp_b,
                       got.amp_c);
            err_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        case (in_kind)
          KIND_SELECT: cur_sel = in_data;
          KIND_WRITE: begin
            if (cur_sel < 8'(NUM_REGS)) begin
              case (cur_sel[3:0])
                REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI, REG_ENV_SHAPE:
                  wv = in_data & 8'h0F;
                REG_NOISE, REG_VOL_A, REG_VOL_B, REG_VOL_C:
                  wv = in_data & 8'h1F;
                REG_MIXER: wv = in_data & 8'h3F;
                default:   wv = in_data;
              endcase
              psg_reg[cur_sel[3:0]] = wv;
              // envelope restart
              if (cur_sel[3:0] == REG_ENV_SHAPE) begin
                env_pos    = '0;
                env_div    = '0;
                env_freeze = 1'b0;
                env_up     = wv[2];
              end
            end
          end
          KIND_READ: begin
            exp_res      = '0;
            exp_res.kind = RES_READ;
            if (cur_sel == 8'(REG_PORT))
              exp_res.value = port_val;
            else if (cur_sel >= 8'(NUM_REGS))
              exp_res.value = READ_NONE;
            else
              exp_res.value = psg_reg[cur_sel[3:0]];
            predicted_outputs.push_back(exp_res);
          end
          KIND_TICK: begin
            for (int c = 0; c < 3; c++) begin
              per = int'({psg_reg[2*c+1][3:0], psg_reg[2*c]});
              if (per == 0) per = 1;
              nxt = (int'(tone_div[c]) + 1) & 32'h7FFF;
              if (nxt >= per * 8) begin
                nxt = 0;
                tone_out[c] = ~tone_out[c];
              end
              tone_div[c] = nxt[14:0];
            end

            per = int'(psg_reg[REG_NOISE][4:0]);
            if (per == 0) per = 1;
            nxt = (int'(noise_div) + 1) & 32'h1FF;
            if (nxt >= per * 16) begin
              nxt  = 0;
              fb   = lfsr[0] ^ lfsr[3];
              lfsr = {fb, lfsr[16:1]};
            end
            noise_div = nxt[8:0];

            if (!env_freeze) begin
              per = int'({psg_reg[ENV_PER_HI], psg_reg[ENV_PER_LO]});
              if (per == 0) per = 1;
              nxt = (int'(env_div) + 1) & 32'h7FFFF;
              if (nxt >= per * 8) begin
                nxt  = 0;
                step = int'(env_pos) + 1;
                if (step >= 32) begin
                  shape = psg_reg[REG_ENV_SHAPE][3:0];
                  if (!shape[3]) begin
                    step       = env_up ? 0 : 31;
                    env_freeze = 1'b1;
                  end else if (shape[0]) begin
                    if (shape[1]) env_up = ~env_up;
                    step       = 31;
                    env_freeze = 1'b1;
                  end else begin
                    if (shape[1]) env_up = ~env_up;
                    step = 0;
                  end
                end
                env_pos = step[4:0];
              end
              env_div = nxt[18:0];
            end
            lvl = env_up ? int'(env_pos) / 2 : (31 - int'(env_pos)) / 2;

            for (int c = 0; c < 3; c++) begin
              t_off = psg_reg[REG_MIXER][c];
              n_off = psg_reg[REG_MIXER][c+3];
              th    = t_off ? 1'b1 : tone_out[c];
              nh    = n_off ? 1'b1 : lfsr[0];
              vol   = psg_reg[REG_VOL_A+c][4] ? lvl : int'(psg_reg[REG_VOL_A+c][3:0]);
              if (t_off && n_off)
                amps[c] = '0;
              else
                amps[c] = (th && nh) ? vol[3:0] : 4'd0;
            end

            exp_res       = '0;
            exp_res.kind  = RES_TICK;
            exp_res.amp_a = amps[0];
            exp_res.amp_b = amps[1];
            exp_res.amp_c = amps[2];
            predicted_outputs.push_back(exp_res);
          end
          KIND_PORT: port_val = in_data;
          default: ;
        endcase
      end
    end
    outstanding = predicted_outputs.size();
  end

endmodule

>>> tb/sound_generator_core_top_tb.sv
`timescale 1ns / 1ps

module sound_generator_core_top_tb import sgc_pkg::*;;

  localparam int         NUM_REGS       = 16;
  localparam int         RUN_ITEMS      = 1225;
  localparam int         CALM_ITEMS     = 1060;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam logic [7:0] REG_ENV_LO     = 8'd11;
  localparam logic [7:0] REG_ENV_HI     = 8'd12;
  localparam logic [7:0] REG_SPARE      = 8'd15;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_kind;
  logic [7:0] in_data;
  logic       out_valid;
  logic       out_stall;
  logic       out_result_kind;
  logic [7:0] out_read_data;
  logic [3:0] out_amp_a;
  logic [3:0] out_amp_b;
  logic [3:0] out_amp_c;

  int err_count;
  int outstanding;
  int items_sent = 0;
  int gap_pct    = 20;
  int stall_pct  = 20;
  bit calm       = 1'b0;
  int quiet      = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sound_generator_core_top #(
    .NUM_REGS(NUM_REGS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_read_data  (out_read_data),
    .out_amp_a      (out_amp_a),
    .out_amp_b      (out_amp_b),
    .out_amp_c      (out_amp_c)
  );

  sgc_checker #(
    .NUM_REGS(NUM_REGS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_read_data  (out_read_data),
    .out_amp_a      (out_amp_a),
    .out_amp_b      (out_amp_b),
    .out_amp_c      (out_amp_c),
    .err_count      (err_count),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result side backpressure in bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && rst_n && $urandom_range(1, 100) <= stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [2:0] k, input logic [7:0] d);
    if (!calm && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= k;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [7:0] r, input logic [7:0] v);
    send_item(KIND_SELECT, r);
    send_item(KIND_WRITE, v);
  endtask

  task automatic tick_burst(input int n);
    repeat (n) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  // short periods most of the time so dividers and the envelope wrap often
  function automatic logic [7:0] reg_value(input logic [7:0] r);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if (r < 8'(REG_NOISE) && !r[0]) begin
      if ($urandom_range(0, 9) < 7) v = 8'($urandom_range(0, 3));
    end else if (r < 8'(REG_NOISE)) begin
      if ($urandom_range(0, 9) < 8) v = 8'd0;
    end else if (r == 8'(REG_NOISE)) begin
      if ($urandom_range(0, 9) < 7) v = 8'($urandom_range(0, 2));
    end else if (r == REG_ENV_LO) begin
      if ($urandom_range(0, 9) < 7) v = 8'($urandom_range(0, 1));
    end else if (r == REG_ENV_HI) begin
      if ($urandom_range(0, 19) < 17) v = 8'd0;
    end
    return v;
  endfunction

  initial begin
    logic [7:0] r;
    int         seg;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_kind  <= KIND_SELECT;
    in_data  <= 8'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: register file, port, out of range select, masks, unknown kinds
    send_item(KIND_READ, 8'hFF);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_SELECT, 8'(REG_PORT));
    send_item(KIND_PORT, 8'hA5);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_WRITE, 8'hFF);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_SELECT, 8'hFF);
    send_item(KIND_WRITE, 8'h00);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_SELECT, 8'(NUM_REGS));
    send_item(KIND_READ, 8'h00);
    write_reg(8'(REG_MIXER), 8'hFF);
    send_item(KIND_READ, 8'h00);
    write_reg(8'(REG_VOL_A), 8'hFF);
    send_item(KIND_READ, 8'h00);
    write_reg(8'(REG_ENV_SHAPE), 8'hFF);
    send_item(KIND_READ, 8'h00);
    write_reg(REG_SPARE, 8'hFF);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_UNUSED_LO, 8'hFF);
    send_item(KIND_UNUSED_LO + 3'd1, 8'h00);
    send_item(KIND_UNUSED_LO + 3'd2, 8'hFF);
    write_reg(8'(REG_MIXER), 8'h00);
    tick_burst(3);

    while (items_sent < RUN_ITEMS) begin
      calm = (items_sent >= CALM_ITEMS);
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      seg = $urandom_range(0, 99);
      if (seg < 35) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 9) != 0)
            r = 8'($urandom_range(0, NUM_REGS - 1));
          else
            r = 8'($urandom_range(NUM_REGS, 255));
          write_reg(r, reg_value(r));
          if ($urandom_range(0, 1) == 0) send_item(KIND_READ, 8'($urandom_range(0, 255)));
        end
      end else if (seg < 75) begin
        tick_burst(($urandom_range(0, 19) == 0) ? $urandom_range(256, 300)
                                                : $urandom_range(1, 24));
      end else if (seg < 83) begin
        write_reg(REG_ENV_LO, reg_value(REG_ENV_LO));
        write_reg(REG_ENV_HI, reg_value(REG_ENV_HI));
        if ($urandom_range(0, 1) == 0)
          write_reg(8'(REG_VOL_A) + 8'($urandom_range(0, 2)),
                    8'h10 | 8'($urandom_range(0, 255)));
        write_reg(8'(REG_ENV_SHAPE), 8'($urandom_range(0, 255)));
        tick_burst(($urandom_range(0, 4) == 0) ? $urandom_range(260, 300)
                                               : $urandom_range(20, 80));
      end else if (seg < 89) begin
        send_item(KIND_PORT, 8'($urandom_range(0, 255)));
        send_item(KIND_SELECT, 8'(REG_PORT));
        send_item(KIND_READ, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
    end

    calm = 1'b1;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
hdl/sgc_pkg.sv
hdl/sgc_regs.sv
hdl/sgc_gen.sv
hdl/sound_generator_core_top.sv
tb/sgc_checker.sv
tb/sound_generator_core_top_tb.sv
